// ===== rtl/icsp_lvp_config_reader_macros.svh =====
// Assertion helpers for the RTL, used by the sequencer.
// Each expects clk and rst_n in the scope where it is used.
`ifndef ICSP_LVP_CONFIG_READER_MACROS_SVH
`define ICSP_LVP_CONFIG_READER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ICSP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define ICSP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/icsp_lvp_pkg.sv =====
package icsp_lvp_pkg;

  // Field lengths in clock periods.
  localparam int KEY_BITS  = 33;
  localparam int CMD_BITS  = 6;
  localparam int WORD_BITS = 16;

  localparam int BIT_W = 9;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_ENTRY_KEY    = 3'd0,
    CFG_WORD_COUNT   = 3'd1,
    CFG_RESET_HOLD   = 3'd2,
    CFG_GAP_TICKS    = 3'd3,
    CFG_LOAD_PAYLOAD = 3'd4
  } cfg_idx_t;

  localparam logic [31:0] RST_ENTRY_KEY    = 32'd1296255056;
  localparam logic [7:0]  RST_WORD_COUNT   = 8'd11;
  localparam logic [7:0]  RST_RESET_HOLD   = 8'd20;
  localparam logic [7:0]  RST_GAP_TICKS    = 8'd1;
  localparam logic [13:0] RST_LOAD_PAYLOAD = 14'd1638;

  typedef struct packed {
    logic [31:0] entry_key;
    logic [7:0]  word_count;
    logic [7:0]  reset_hold;
    logic [7:0]  gap_ticks;
    logic [13:0] load_payload;
  } cfg_regs_t;

  // Sequence phases.
  typedef enum logic [1:0] {
    PH_ENTRY = 2'd0,
    PH_READ  = 2'd1,
    PH_DONE  = 2'd2
  } phase_t;

  // Steps of the entry phase.
  localparam logic [2:0] ST_START     = 3'd0;
  localparam logic [2:0] ST_PULSE     = 3'd1;
  localparam logic [2:0] ST_HOLD      = 3'd2;
  localparam logic [2:0] ST_KEY       = 3'd3;
  localparam logic [2:0] ST_LOAD_CMD  = 3'd4;
  localparam logic [2:0] ST_LOAD_DATA = 3'd5;
  localparam logic [2:0] ENTRY_STEPS  = 3'd6;

  // Steps of the read phase.
  localparam logic [2:0] ST_RD_CMD   = 3'd0;
  localparam logic [2:0] ST_RD_DATA  = 3'd1;
  localparam logic [2:0] ST_INC_CMD  = 3'd2;
  localparam logic [2:0] READ_STEPS  = 3'd3;

  localparam logic [15:0] CMD_READ = 16'd4;
  localparam logic [15:0] CMD_INC  = 16'd6;

  localparam logic [BIT_W-1:0] LAST_CAPTURE_BIT = 9'd15;

  // One tick's outcome.
  typedef struct packed {
    logic        reset_line;
    logic        clock_line;
    logic        data_out;
    logic        data_drive;
    logic        word_valid;
    logic [13:0] word_value;
    logic        phase_led;
    logic        finished;
  } tick_res_t;

endpackage

// ===== rtl/icsp_lvp_cfg.sv =====
module icsp_lvp_cfg
  import icsp_lvp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output cfg_regs_t   regs
);

  cfg_regs_t regs_r;
  cfg_regs_t regs_nxt;

  always_comb begin
    regs_nxt = regs_r;
    if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_ENTRY_KEY:    regs_nxt.entry_key    = cfg_data;
        CFG_WORD_COUNT:   regs_nxt.word_count   = cfg_data[7:0];
        CFG_RESET_HOLD:   regs_nxt.reset_hold   = cfg_data[7:0];
        CFG_GAP_TICKS:    regs_nxt.gap_ticks    = cfg_data[7:0];
        CFG_LOAD_PAYLOAD: regs_nxt.load_payload = cfg_data[13:0];
        default:          regs_nxt = regs_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.entry_key    <= RST_ENTRY_KEY;
      regs_r.word_count   <= RST_WORD_COUNT;
      regs_r.reset_hold   <= RST_RESET_HOLD;
      regs_r.gap_ticks    <= RST_GAP_TICKS;
      regs_r.load_payload <= RST_LOAD_PAYLOAD;
    end else begin
      regs_r <= regs_nxt;
    end
  end

  assign regs = regs_r;

endmodule

// ===== rtl/icsp_lvp_seq.sv =====
module icsp_lvp_seq
  import icsp_lvp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_regs_t cfg,
  input  logic      fire,
  input  logic      data_in,
  input  logic      tx_busy,
  output tick_res_t res
);

  `include "icsp_lvp_config_reader_macros.svh"

  phase_t            phase_r, phase_nxt;
  logic [2:0]        step_r, step_nxt;
  logic [BIT_W-1:0]  bit_r, bit_nxt;
  logic [7:0]        rep_r, rep_nxt;
  logic [15:0]       cap_r, cap_nxt;
  logic              rst_pin_r, rst_pin_nxt;
  logic              clk_pin_r, clk_pin_nxt;
  logic              dat_pin_r, dat_pin_nxt;
  logic              drv_pin_r, drv_pin_nxt;
  logic              led_r, led_nxt;
  logic              done_r, done_nxt;

  logic [BIT_W-1:0]  len;
  logic [BIT_W:0]    limit;
  logic              is_input;
  logic              adv;
  logic [BIT_W-1:0]  bc1;
  logic [2:0]        st1;
  logic [7:0]        rep1;
  logic [7:0]        times;
  logic              wvalid;

  function automatic logic [BIT_W-1:0] step_len(phase_t ph, logic [2:0] st);
    logic [BIT_W-1:0] l;
    l = '0;
    if (ph == PH_ENTRY) begin
      if (st == ST_KEY)       l = BIT_W'(KEY_BITS);
      if (st == ST_LOAD_CMD)  l = BIT_W'(CMD_BITS);
      if (st == ST_LOAD_DATA) l = BIT_W'(WORD_BITS);
    end else if (ph == PH_READ) begin
      l = (st == ST_RD_DATA) ? BIT_W'(WORD_BITS) : BIT_W'(CMD_BITS);
    end
    return l;
  endfunction

  function automatic logic [7:0] step_post(phase_t ph, logic [2:0] st, cfg_regs_t c);
    logic [7:0] p;
    p = c.gap_ticks;
    if (ph == PH_ENTRY) begin
      if (st == ST_START || st == ST_KEY) p = '0;
      if (st == ST_HOLD)                  p = c.reset_hold;
    end
    return p;
  endfunction

  function automatic logic step_bit(phase_t ph, logic [2:0] st, logic [BIT_W-1:0] k,
                                    cfg_regs_t c);
    logic [BIT_W-1:0] km1;
    logic [15:0]      code;
    logic             b;
    km1  = k - BIT_W'(1);
    code = '0;
    b    = 1'b0;
    if (ph == PH_ENTRY) begin
      if (st == ST_KEY && k < BIT_W'(32)) b = c.entry_key[k[4:0]];
      if (st == ST_LOAD_DATA && k >= BIT_W'(1) && k <= BIT_W'(14))
        b = c.load_payload[km1[3:0]];
    end else if (ph == PH_READ) begin
      if (st == ST_RD_CMD)  code = CMD_READ;
      if (st == ST_INC_CMD) code = CMD_INC;
      if (k < BIT_W'(16)) b = code[k[3:0]];
    end
    return b;
  endfunction

  assign len      = step_len(phase_r, step_r);
  assign limit    = {1'b0, len} + (BIT_W+1)'(step_post(phase_r, step_r, cfg));
  assign is_input = (phase_r == PH_READ) && (step_r == ST_RD_DATA);
  assign bc1      = bit_r + BIT_W'(1);

  always_comb begin
    phase_nxt   = phase_r;
    step_nxt    = step_r;
    bit_nxt     = bit_r;
    rep_nxt     = rep_r;
    cap_nxt     = cap_r;
    rst_pin_nxt = rst_pin_r;
    clk_pin_nxt = clk_pin_r;
    dat_pin_nxt = dat_pin_r;
    drv_pin_nxt = drv_pin_r;
    led_nxt     = led_r;
    done_nxt    = done_r;
    adv         = 1'b0;
    wvalid      = 1'b0;
    st1         = step_r + 3'd1;
    rep1        = rep_r + 8'd1;
    times       = (phase_r == PH_ENTRY) ? 8'd1 : cfg.word_count;

    if (!done_r) begin
      if (bit_r < len) begin
        if (clk_pin_r) begin
          // falling edge: sample when reading, wait while the transmitter is busy
          if (!tx_busy) begin
            clk_pin_nxt = 1'b0;
            if (is_input) begin
              if (bit_r <= LAST_CAPTURE_BIT) cap_nxt[bit_r[3:0]] = data_in;
              if (bit_r == LAST_CAPTURE_BIT) wvalid = 1'b1;
            end
            adv = 1'b1;
          end
        end else begin
          clk_pin_nxt = 1'b1;
          if (!is_input) dat_pin_nxt = step_bit(phase_r, step_r, bit_r, cfg);
        end
      end else begin
        adv = 1'b1;
      end

      if (adv) begin
        if ({1'b0, bc1} < limit) begin
          bit_nxt = bc1;
        end else begin
          bit_nxt = '0;
          if (st1 >= ((phase_r == PH_ENTRY) ? ENTRY_STEPS : READ_STEPS)) begin
            st1 = '0;
            if (rep1 >= times) begin
              rep1    = '0;
              led_nxt = ~led_r;
              if (phase_r == PH_ENTRY) begin
                phase_nxt = PH_READ;
              end else begin
                phase_nxt = PH_DONE;
                done_nxt  = 1'b1;
              end
            end
            rep_nxt = rep1;
          end
          step_nxt = st1;
          if (!done_nxt) begin
            drv_pin_nxt = !((phase_nxt == PH_READ) && (st1 == ST_RD_DATA));
            if (phase_nxt == PH_ENTRY && st1 == ST_PULSE) rst_pin_nxt = 1'b1;
            if (phase_nxt == PH_ENTRY && st1 == ST_HOLD)  rst_pin_nxt = 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_ENTRY;
      step_r    <= '0;
      bit_r     <= '0;
      rep_r     <= '0;
      cap_r     <= '0;
      rst_pin_r <= 1'b1;
      clk_pin_r <= 1'b0;
      dat_pin_r <= 1'b0;
      drv_pin_r <= 1'b1;
      led_r     <= 1'b0;
      done_r    <= 1'b0;
    end else if (fire) begin
      phase_r   <= phase_nxt;
      step_r    <= step_nxt;
      bit_r     <= bit_nxt;
      rep_r     <= rep_nxt;
      cap_r     <= cap_nxt;
      rst_pin_r <= rst_pin_nxt;
      clk_pin_r <= clk_pin_nxt;
      dat_pin_r <= dat_pin_nxt;
      drv_pin_r <= drv_pin_nxt;
      led_r     <= led_nxt;
      done_r    <= done_nxt;
    end
  end

  always_comb begin
    res.reset_line = rst_pin_nxt;
    res.clock_line = clk_pin_nxt;
    res.data_out   = dat_pin_nxt;
    res.data_drive = drv_pin_nxt;
    res.word_valid = wvalid;
    res.word_value = wvalid ? cap_nxt[14:1] : '0;
    res.phase_led  = led_nxt;
    res.finished   = done_nxt;
  end

  `ICSP_ASSERT_NEXT(a_done_sticky, done_r, done_r, "finished flag dropped")
  `ICSP_ASSERT_NOW(a_done_phase, done_r, phase_r == PH_DONE, "finished outside done phase")
  `ICSP_ASSERT_NOW(a_word_in_read, wvalid, is_input && !drv_pin_r,
    "word completed outside the released read field")
  `ICSP_ASSERT_NEXT(a_busy_holds_clock,
    fire && !done_r && clk_pin_r && tx_busy && (bit_r < len),
    clk_pin_r && $stable(bit_r), "falling edge taken while transmitter busy")

endmodule

// ===== rtl/icsp_lvp_config_reader.sv =====
// Requests pass the input register, the sequencer and the result register.
// Throughput: one request per cycle if not stalled; a tick is one sequencer pass.
// Stall on the result side holds the output register, then the input register.
// Reset (rst_n low, synchronous): reset pin high, clock and data low, data driven,
// all counters cleared and configuration registers back to their defaults.
module icsp_lvp_config_reader
  import icsp_lvp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // configuration write port
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  // tick requests
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_data_in,
  input  logic        in_tx_busy,
  // per-tick results
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_reset_line,
  output logic        out_clock_line,
  output logic        out_data_out,
  output logic        out_data_drive,
  output logic        out_word_valid,
  output logic [13:0] out_word_value,
  output logic        out_phase_led,
  output logic        out_finished
);

  cfg_regs_t cfg;
  tick_res_t res;
  tick_res_t res_r;

  logic in_vld_r;
  logic din_r;
  logic busy_r;
  logic out_vld_r;
  logic out_hold;
  logic fire;

  icsp_lvp_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .regs      (cfg)
  );

  // A held result blocks the sequencer; a blocked sequencer blocks the input stage.
  assign out_hold = out_vld_r && out_stall;
  assign fire     = in_vld_r && !out_hold;
  assign in_stall = in_vld_r && out_hold;

  // Input register: take a new request whenever the stage ahead can move.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      din_r  <= in_data_in;
      busy_r <= in_tx_busy;
    end
  end

  icsp_lvp_seq u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .fire    (fire),
    .data_in (din_r),
    .tx_busy (busy_r),
    .res     (res)
  );

  // Result register: load on each tick, drop once taken, hold while stalled.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (fire) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= res;
    end
  end

  assign out_valid      = out_vld_r;
  assign out_reset_line = res_r.reset_line;
  assign out_clock_line = res_r.clock_line;
  assign out_data_out   = res_r.data_out;
  assign out_data_drive = res_r.data_drive;
  assign out_word_valid = res_r.word_valid;
  assign out_word_value = res_r.word_value;
  assign out_phase_led  = res_r.phase_led;
  assign out_finished   = res_r.finished;

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
module tb;
  import icsp_lvp_pkg::*;

  localparam int QUIET_LIMIT      = 1000;  // cycles with no handshake while work is pending
  localparam int LONG_HOLD_CYCLES = 80;
  localparam int MAX_REPORTS      = 10;
  localparam int DRAIN_CYCLES     = 8;
  localparam int BUSY_PCT         = 30;
  localparam logic [2:0] CFG_FIRST_UNUSED = 3'd5;
  localparam logic [2:0] CFG_LAST_UNUSED  = 3'd7;

  typedef struct packed {
    logic data_in;
    logic tx_busy;
  } tick_req_t;

  logic        clk;
  logic        rst_n          = 1'b0;
  logic        cfg_we         = 1'b0;
  logic [2:0]  cfg_index      = '0;
  logic [31:0] cfg_data       = '0;
  logic        in_valid       = 1'b0;
  logic        in_stall;
  logic        in_data_in     = 1'b0;
  logic        in_tx_busy     = 1'b0;
  logic        out_valid;
  logic        out_stall      = 1'b0;
  logic        out_reset_line;
  logic        out_clock_line;
  logic        out_data_out;
  logic        out_data_drive;
  logic        out_word_valid;
  logic [13:0] out_word_value;
  logic        out_phase_led;
  logic        out_finished;

  // Pending tick requests and the pin states they are expected to produce.
  tick_req_t tick_q[$];
  tick_res_t outcome_q[$];

  // Traffic shaping, set per test phase.
  int send_idle_pct     = 0;
  int stall_pct         = 0;
  int long_holds_wanted = 0;
  int long_holds_done   = 0;
  int hold_left         = 0;

  logic req_taken   = 1'b0;
  int   fail_count  = 0;
  int   result_no   = 0;
  int   quiet_cycles = 0;

  // Sequencer state of the programming master, mirrored tick by tick.
  phase_t      seq_phase = PH_ENTRY;
  logic [2:0]  seq_step  = '0;
  logic [8:0]  seq_bit   = '0;
  logic [7:0]  seq_rep   = '0;
  logic [15:0] shift_cap = '0;
  logic        pin_rst   = 1'b1;
  logic        pin_clk   = 1'b0;
  logic        pin_dat   = 1'b0;
  logic        pin_drv   = 1'b1;
  logic        led_lvl   = 1'b0;
  logic        seq_done  = 1'b0;
  cfg_regs_t   regs      = '{RST_ENTRY_KEY, RST_WORD_COUNT, RST_RESET_HOLD,
                             RST_GAP_TICKS, RST_LOAD_PAYLOAD};

  icsp_lvp_config_reader i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data_in     (in_data_in),
    .in_tx_busy     (in_tx_busy),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_reset_line (out_reset_line),
    .out_clock_line (out_clock_line),
    .out_data_out   (out_data_out),
    .out_data_drive (out_data_drive),
    .out_word_valid (out_word_valid),
    .out_word_value (out_word_value),
    .out_phase_led  (out_phase_led),
    .out_finished   (out_finished)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Sequencer mirror
  // ---------------------------------------------------------------------------

  // Clocked bits in the current step.
  function automatic int field_len();
    if (seq_phase == PH_ENTRY) begin
      if (seq_step == ST_KEY) return KEY_BITS;
      if (seq_step == ST_LOAD_CMD) return CMD_BITS;
      if (seq_step == ST_LOAD_DATA) return WORD_BITS;
      return 0;
    end
    if (seq_phase == PH_READ) return (seq_step == ST_RD_DATA) ? WORD_BITS : CMD_BITS;
    return 0;
  endfunction

  // Idle ticks that follow the clocked bits of the current step.
  function automatic int field_tail();
    if (seq_phase == PH_ENTRY) begin
      if (seq_step == ST_START || seq_step == ST_KEY) return 0;
      if (seq_step == ST_HOLD) return int'(regs.reset_hold);
    end
    return int'(regs.gap_ticks);
  endfunction

  function automatic logic reading();
    return seq_phase == PH_READ && seq_step == ST_RD_DATA;
  endfunction

  // Level to put on the data pin for bit k of the current field, LSB first.
  function automatic logic drive_bit(int k);
    logic [15:0] code;
    if (seq_phase == PH_ENTRY) begin
      if (seq_step == ST_KEY) return (k < 32) ? regs.entry_key[k] : 1'b0;
      if (seq_step == ST_LOAD_DATA) begin
        // start bit and stop bit frame the 14 payload bits
        return (k >= 1 && k <= 14) ? regs.load_payload[k - 1] : 1'b0;
      end
      return 1'b0;
    end
    if (seq_phase == PH_READ) begin
      code = (seq_step == ST_RD_CMD) ? CMD_READ : (seq_step == ST_INC_CMD) ? CMD_INC : '0;
      return (k < 16) ? code[k] : 1'b0;
    end
    return 1'b0;
  endfunction

  function automatic void enter_step();
    pin_drv = !reading();
    if (seq_phase == PH_ENTRY && seq_step == ST_PULSE) pin_rst = 1'b1;
    if (seq_phase == PH_ENTRY && seq_step == ST_HOLD) pin_rst = 1'b0;
  endfunction

  // Advance one tick through bits, tail, steps, repetitions and phases.
  function automatic void step_on();
    int len;
    int times;
    len = field_len();
    seq_bit = seq_bit + 9'd1;
    if (int'(seq_bit) < len + field_tail()) return;
    seq_bit  = '0;
    seq_step = seq_step + 3'd1;
    if (seq_step >= ((seq_phase == PH_ENTRY) ? ENTRY_STEPS : READ_STEPS)) begin
      // a word count of zero still runs the current repetition to its end
      times    = (seq_phase == PH_ENTRY) ? 1 : int'(regs.word_count);
      seq_step = '0;
      seq_rep  = seq_rep + 8'd1;
      if (int'(seq_rep) >= times) begin
        seq_rep = '0;
        led_lvl = ~led_lvl;
        if (seq_phase == PH_ENTRY) begin
          seq_phase = PH_READ;
        end else begin
          seq_phase = PH_DONE;
          seq_done  = 1'b1;
          return;
        end
      end
    end
    enter_step();
  endfunction

  // Pin levels and read word produced by one accepted tick request.
  function automatic tick_res_t tick_step(logic din, logic busy);
    tick_res_t r;
    r = '0;
    if (!seq_done) begin
      if (int'(seq_bit) < field_len()) begin
        if (pin_clk) begin
          // the falling edge waits for the transmitter
          if (!busy) begin
            pin_clk = 1'b0;
            if (reading()) begin
              if (seq_bit < 9'd16) shift_cap[seq_bit[3:0]] = din;
              if (seq_bit == LAST_CAPTURE_BIT) begin
                r.word_valid = 1'b1;
                r.word_value = shift_cap[14:1];
              end
            end
            step_on();
          end
        end else begin
          pin_clk = 1'b1;
          // while released, the data pin keeps its last driven level
          if (!reading()) pin_dat = drive_bit(int'(seq_bit));
        end
      end else begin
        step_on();
      end
    end
    r.reset_line = pin_rst;
    r.clock_line = pin_clk;
    r.data_out   = pin_dat;
    r.data_drive = pin_drv;
    r.phase_led  = led_lvl;
    r.finished   = seq_done;
    return r;
  endfunction

  function automatic string pins_str(tick_res_t r);
    return $sformatf("rst=%b clk=%b dat=%b drv=%b wv=%b word=%04h led=%b fin=%b",
                     r.reset_line, r.clock_line, r.data_out, r.data_drive,
                     r.word_valid, r.word_value, r.phase_led, r.finished);
  endfunction

  function automatic void note_failure(string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS) $display("ERROR: %s", msg);
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: present the next request once the previous one is taken
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst_n && (!in_valid || req_taken)) begin
      if (tick_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        {in_data_in, in_tx_busy} <= tick_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus long hold-offs on request from the sequence below.
  always @(negedge clk) begin
    if (long_holds_done < long_holds_wanted) begin
      long_holds_done <= long_holds_done + 1;
      hold_left <= LONG_HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: check results, predict accepted requests, watch for a hang
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    tick_res_t got;
    tick_res_t want;
    if (rst_n) begin
      req_taken <= in_valid && !in_stall;
      // check before predicting, so a premature result cannot pair with its own request
      if (out_valid && !out_stall) begin
        got = {out_reset_line, out_clock_line, out_data_out, out_data_drive,
               out_word_valid, out_word_value, out_phase_led, out_finished};
        if (outcome_q.size() == 0) begin
          note_failure($sformatf("result %0d with no request pending: %s",
                                 result_no, pins_str(got)));
        end else begin
          want = outcome_q.pop_front();
          if (got !== want) begin
            note_failure($sformatf("result %0d\n  want %s\n  got  %s",
                                   result_no, pins_str(want), pins_str(got)));
          end
        end
        result_no++;
      end
      if (in_valid && !in_stall) outcome_q.push_back(tick_step(in_data_in, in_tx_busy));

      if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
          (tick_q.size() == 0 && !in_valid && outcome_q.size() == 0)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("simulation failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence of test phases
  // ---------------------------------------------------------------------------

  // Write one register; the mirror follows at once since the block is idle.
  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      CFG_ENTRY_KEY:    regs.entry_key    = val;
      CFG_WORD_COUNT:   regs.word_count   = val[7:0];
      CFG_RESET_HOLD:   regs.reset_hold   = val[7:0];
      CFG_GAP_TICKS:    regs.gap_ticks    = val[7:0];
      CFG_LOAD_PAYLOAD: regs.load_payload = val[13:0];
      default: ;  // unused indexes are dropped
    endcase
  endtask

  task automatic close_writes();
    @(negedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic push_req(logic din, logic busy);
    tick_q.push_back('{data_in: din, tx_busy: busy});
  endtask

  // Hold until every request is taken and every result has come back.
  task automatic wait_idle();
    do begin
      @(posedge clk);
      #1;
    end while (tick_q.size() != 0 || in_valid || outcome_q.size() != 0);
  endtask

  task automatic run_phase(int count, int idle_pct, int stall_pct_v);
    send_idle_pct = idle_pct;
    stall_pct     = stall_pct_v;
    repeat (count) push_req(1'($urandom_range(1)), $urandom_range(99) < BUSY_PCT);
    wait_idle();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Fastest entry: no pulse gap, no reset hold, no field gaps, payload all ones.
    write_reg(CFG_ENTRY_KEY, $urandom);
    write_reg(CFG_WORD_COUNT, 32'd255);
    write_reg(CFG_RESET_HOLD, 32'd0);
    write_reg(CFG_GAP_TICKS, 32'd0);
    write_reg(CFG_LOAD_PAYLOAD, 32'h3FFF);
    for (int i = CFG_FIRST_UNUSED; i <= CFG_LAST_UNUSED; i++) write_reg(3'(i), $urandom);
    close_writes();

    // Directed start: every data/busy pairing, and busy runs that hold a falling edge.
    for (int k = 0; k < 24; k++) push_req(k[1], (k >= 6 && k < 10) || k == 15 || k == 20);
    long_holds_wanted = 1;  // back up the pipe while requests keep coming
    run_phase(350, 0, 0);

    // Longest gaps; key and payload at zero take effect only if still in entry.
    write_reg(CFG_GAP_TICKS, 32'd255);
    write_reg(CFG_ENTRY_KEY, 32'h0000_0000);
    write_reg(CFG_LOAD_PAYLOAD, 32'h0000);
    close_writes();
    run_phase(300, 71, 0);

    write_reg(CFG_GAP_TICKS, 32'd2);
    write_reg(CFG_RESET_HOLD, 32'd255);
    write_reg(CFG_ENTRY_KEY, 32'hFFFF_FFFF);
    close_writes();
    run_phase(400, 0, 71);

    write_reg(CFG_GAP_TICKS, $urandom_range(3));
    write_reg(CFG_RESET_HOLD, $urandom_range(255));
    write_reg(CFG_LOAD_PAYLOAD, $urandom_range(16383));
    close_writes();
    run_phase(500, 24, 24);

    // Zero word count ends the sequence after the repetition in progress.
    write_reg(CFG_WORD_COUNT, 32'd0);
    write_reg(CFG_GAP_TICKS, 32'd1);
    close_writes();
    long_holds_wanted = 2;
    run_phase(250, 0, 0);

    // Finished: further ticks must leave everything alone.
    write_reg(CFG_WORD_COUNT, 32'd1);
    write_reg(CFG_ENTRY_KEY, $urandom);
    write_reg(CFG_GAP_TICKS, 32'd0);
    close_writes();
    run_phase(150, 24, 24);

    // Let any stray result surface before the verdict.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
